>>> hdl/symbol_table_byte_decompressor_core_macros.svh
// Assertion helpers used by the core's expand module.
// Both expect clk and rst_n in scope of the module that uses them.
`ifndef SYMBOL_TABLE_BYTE_DECOMPRESSOR_CORE_MACROS_SVH
`define SYMBOL_TABLE_BYTE_DECOMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication.
`define STBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/stbd_pkg.sv
`timescale 1ns / 1ps

package stbd_pkg;

    localparam int OUT_BYTES = 8;
    localparam int COUNT_W   = 21;
    localparam int CFG_IDX_W = 8;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_DATA = 1'b1;
    localparam logic [7:0] ESCAPE_CODE = 8'hFF;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SYMBOLS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY   = 8'd1;

    localparam logic [COUNT_W-1:0] OUT_CAPACITY_RESET = 21'd65536;

    typedef struct packed {
        logic        kind;
        logic [7:0]  entry_code;
        logic [3:0]  entry_len;
        logic [63:0] entry_bytes;
        logic [7:0]  data_byte;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0]        out_bytes;
        logic [3:0]         out_count;
        logic [1:0]         status;
        logic               block_end;
        logic [COUNT_W-1:0] block_total;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [COUNT_W-1:0]   wr_data;
    } cfg_item_t;

    // Table lookup result, valid in the cycle after the read is issued.
    typedef struct packed {
        logic        present;
        logic [3:0]  len;
        logic [63:0] bytes;
    } lookup_t;

endpackage

>>> hdl/stbd_stream_if.sv
`timescale 1ns / 1ps

interface stbd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/stbd_ram.sv
`timescale 1ns / 1ps

module stbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/stbd_table.sv
`timescale 1ns / 1ps

module stbd_table
    import stbd_pkg::*;
#(
    parameter int TABLE_CODES      = 256,
    parameter int MAX_SYMBOL_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_en,
    input  logic [7:0]  load_code,
    input  logic [3:0]  load_len,
    input  logic [63:0] load_bytes,
    input  logic        look_en,
    input  logic [7:0]  look_code,
    output lookup_t     lookup
);

    localparam int AW = $clog2(TABLE_CODES);
    localparam int LW = $clog2(MAX_SYMBOL_BYTES + 1);
    localparam int BW = 8 * MAX_SYMBOL_BYTES;

    logic [TABLE_CODES-1:0] written_reg;
    logic [TABLE_CODES-1:0] written_next;
    logic                   present_reg;
    logic                   load_in_table;
    logic                   look_in_table;
    logic [LW-1:0]          len_sat;
    logic [LW+BW-1:0]       rd_word;

    assign load_in_table = {1'b0, load_code} < 9'(TABLE_CODES);
    assign look_in_table = {1'b0, look_code} < 9'(TABLE_CODES);

    // Clamp oversize lengths to the widest symbol.
    assign len_sat = (load_len > 4'(MAX_SYMBOL_BYTES)) ? LW'(MAX_SYMBOL_BYTES)
                                                       : load_len[LW-1:0];

    stbd_ram #(
        .WIDTH (LW + BW),
        .DEPTH (TABLE_CODES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (load_en && load_in_table),
        .wr_addr (load_code[AW-1:0]),
        .wr_data ({len_sat, load_bytes[BW-1:0]}),
        .rd_en   (look_en),
        .rd_addr (look_code[AW-1:0]),
        .rd_data (rd_word)
    );

    always_comb
    begin
        written_next = written_reg;
        if (load_en && load_in_table)
        begin
            written_next[load_code[AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            present_reg <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (look_en)
            begin
                present_reg <= look_in_table && written_reg[look_code[AW-1:0]];
            end
        end
    end

    // An entry never loaded reads as length zero.
    always_comb
    begin
        lookup.present = present_reg;
        lookup.len     = present_reg ? 4'(rd_word[LW+BW-1:BW]) : 4'd0;
        lookup.bytes   = 64'(rd_word[BW-1:0]);
    end

endmodule

>>> hdl/stbd_expand.sv
`timescale 1ns / 1ps
`include "symbol_table_byte_decompressor_core_macros.svh"

module stbd_expand
    import stbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take_en,
    input  logic [7:0]          take_code,
    input  logic                take_last,
    output logic                can_take,
    input  lookup_t             lookup,
    input  logic [7:0]          active_symbols,
    input  logic [COUNT_W-1:0]  out_capacity,
    stbd_stream_if.source       res
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [7:0]         s1_code_reg;
    logic               s1_last_reg;
    logic               esc_reg;
    logic               esc_next;
    logic [COUNT_W-1:0] produced_reg;
    logic [COUNT_W-1:0] produced_next;
    logic               err_reg;
    logic               err_next;
    logic               out_valid_reg;
    out_item_t          out_reg;
    out_item_t          out_next;
    logic               out_load;
    logic               s1_adv;
    logic               mapped;
    logic [3:0]         n;
    logic [63:0]        bytes;
    logic [1:0]         status;
    logic [COUNT_W:0]   sum;

    assign out_load = !out_valid_reg || res.ready;
    assign s1_adv   = s1_valid_reg && out_load;
    assign can_take = !s1_valid_reg || out_load;

    assign mapped = lookup.present && (s1_code_reg < active_symbols) && (lookup.len != 4'd0);

    always_comb
    begin
        n        = 4'd0;
        bytes    = '0;
        status   = STATUS_OK;
        esc_next = esc_reg;
        err_next = err_reg;
        if (err_reg)
        begin
            esc_next = 1'b0;
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            n        = 4'd1;
            bytes    = 64'(s1_code_reg);
        end
        else if (s1_code_reg == ESCAPE_CODE)
        begin
            if (s1_last_reg)
            begin
                status = STATUS_TRUNCATED;
            end
            else
            begin
                esc_next = 1'b1;
            end
        end
        else if (mapped)
        begin
            n = lookup.len;
            for (int i = 0; i < OUT_BYTES; i++)
            begin
                if (4'(i) < lookup.len)
                begin
                    bytes[8*i +: 8] = lookup.bytes[8*i +: 8];
                end
            end
        end
        else
        begin
            n     = 4'd1;
            bytes = 64'(s1_code_reg);
        end

        sum           = {1'b0, produced_reg} + (COUNT_W + 1)'(n);
        produced_next = produced_reg;
        if (n != 4'd0)
        begin
            if (sum > {1'b0, out_capacity})
            begin
                status   = STATUS_OVERFLOW;
                err_next = 1'b1;
                n        = 4'd0;
                bytes    = '0;
            end
            else
            begin
                produced_next = sum[COUNT_W-1:0];
            end
        end
        if (status == STATUS_TRUNCATED)
        begin
            err_next = 1'b1;
        end

        out_next.out_bytes   = bytes;
        out_next.out_count   = n;
        out_next.status      = status;
        out_next.block_end   = s1_last_reg;
        out_next.block_total = produced_next;

        // Drop per-block state once the last byte is through.
        if (s1_last_reg)
        begin
            esc_next      = 1'b0;
            produced_next = '0;
            err_next      = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            produced_reg  <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                esc_reg      <= esc_next;
                produced_reg <= produced_next;
                err_reg      <= err_next;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_en)
        begin
            s1_code_reg <= take_code;
            s1_last_reg <= take_last;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    `STBD_ASSERT_NXT(a_err_suppresses, s1_adv && err_reg, out_reg.out_count == 4'd0 && out_reg.status == STATUS_OK, "output not suppressed after error")
    `STBD_ASSERT_NXT(a_literal_one_byte, s1_adv && esc_reg && !err_reg, out_reg.out_count == 4'd1 || out_reg.status == STATUS_OVERFLOW, "escaped literal not one byte")
    `STBD_ASSERT_NXT(a_block_end_clears, s1_adv && s1_last_reg, produced_reg == '0 && !esc_reg && !err_reg, "block state not cleared at block end")
    `STBD_ASSERT_IMP(a_take_when_free, take_en, can_take, "stage taken while occupied")

endmodule

>>> hdl/symbol_table_byte_decompressor_core.sv
`timescale 1ns / 1ps

// Symbol table byte decompressor.
// items: load transactions (kind 0) write one table entry; data transactions
//   (kind 1) carry one compressed byte and give exactly one result.
// results: expanded bytes, count, status, block end flag and running total.
// cfg: register writes (index 0 active_symbols, index 1 out_capacity),
//   always ready; write only while the block is idle.
// Throughput: one transaction per cycle while results is ready, set by the single
//   table read per data byte on one port of the table memory.
// Pipeline: the table read and the expand stage load when a data transaction
//   is accepted; the result register then loads from the expand stage once
//   it is empty or results is ready.
// Reset: table lengths clear at once through per-entry valid flops, no
//   clearing pass; escape, count and error state clear; active_symbols 0,
//   out_capacity 65536.
// Stall: when results is not ready, the result register holds, one more
//   data byte waits in the expand stage, and items then deasserts ready.
module symbol_table_byte_decompressor_core
    import stbd_pkg::*;
#(
    parameter int TABLE_CODES      = 256,
    parameter int MAX_SYMBOL_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    stbd_stream_if.sink   items,
    stbd_stream_if.source results,
    stbd_stream_if.sink   cfg
);

    logic               can_take;
    logic               accept;
    logic               load_en;
    logic               take_en;
    lookup_t            lookup;
    logic [7:0]         active_symbols_reg;
    logic [COUNT_W-1:0] out_capacity_reg;

    assign items.ready = can_take;
    assign accept      = items.valid && can_take;
    assign load_en     = accept && (items.payload.kind == KIND_LOAD);
    assign take_en     = accept && (items.payload.kind == KIND_DATA);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_symbols_reg <= '0;
            out_capacity_reg   <= OUT_CAPACITY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.reg_index)
                REG_ACTIVE_SYMBOLS: active_symbols_reg <= cfg.payload.wr_data[7:0];
                REG_OUT_CAPACITY:   out_capacity_reg   <= cfg.payload.wr_data;
                default:            ;
            endcase
        end
    end

    stbd_table #(
        .TABLE_CODES      (TABLE_CODES),
        .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load_code  (items.payload.entry_code),
        .load_len   (items.payload.entry_len),
        .load_bytes (items.payload.entry_bytes),
        .look_en    (take_en),
        .look_code  (items.payload.data_byte),
        .lookup     (lookup)
    );

    stbd_expand u_expand (
        .clk            (clk),
        .rst_n          (rst_n),
        .take_en        (take_en),
        .take_code      (items.payload.data_byte),
        .take_last      (items.payload.last_byte),
        .can_take       (can_take),
        .lookup         (lookup),
        .active_symbols (active_symbols_reg),
        .out_capacity   (out_capacity_reg),
        .res            (results)
    );

endmodule
